// ===== sv/bptq_pkg.sv =====
// types and constants shared by the bounded priority task queue
// entry layout, request and status codes; no dependencies
`default_nettype none

package bptq_pkg;

  localparam int unsigned TagW       = 16;
  localparam int unsigned StampW     = 32;
  localparam int unsigned PrioW      = 3;
  localparam int unsigned PrioLevels = 3;
  localparam logic [PrioW-1:0] DefaultPrio = PrioW'(2);

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned KindW    = 2;
  localparam int unsigned LimitW   = 5;
  localparam int unsigned FillW    = 5;
  localparam int unsigned OutPrioW = 2;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [PrioW-1:0]  prio;
    logic [TagW-1:0]   tag;
  } entry_t;

  typedef enum logic [KindW-1:0] {
    REQ_TAIL  = 2'd0,
    REQ_ORDER = 2'd1,
    REQ_POP   = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [KindW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== sv/bptq_ram.sv =====
// generic simple dual-port ram with registered read
// one write and one read port per cycle; no dependencies
`default_nettype none

module bptq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/bptq_cmp.sv =====
// shared ordering comparator of the task queue
// decides whether a new entry goes before a held one; uses bptq_pkg
`default_nettype none

module bptq_cmp (
  input  wire bptq_pkg::entry_t new_i,
  input  wire bptq_pkg::entry_t held_i,
  output logic                  before_o
);

  logic prio_less;
  logic prio_equal;
  logic stamp_less;

  assign prio_less  = new_i.prio < held_i.prio;
  assign prio_equal = new_i.prio == held_i.prio;
  assign stamp_less = new_i.stamp < held_i.stamp;

  // strict compare keeps equal stamps in arrival order
  assign before_o = prio_less || (prio_equal && stamp_less);

endmodule

`default_nettype wire

// ===== sv/bounded_priority_task_queue_unit.sv =====
// bounded priority task queue: top level with the request sequencer
// uses bptq_pkg, bptq_ram and bptq_cmp
`default_nettype none

// The queue holds up to DEPTH entries in a circular ram (head pointer and
// fill count). A pop reads the head slot, then takes the entry and advances
// the head; a plain push writes the new entry at the tail. A priority push
// walks the held entries from the head through one shared comparator (ram
// read, then compare for each entry examined), and then moves the entries
// behind the insertion point up by one slot (read, write back for each
// entry moved) before it writes the new entry. One request is served at a
// time: s_axis_tready is high only while the sequencer is idle, and the
// result is held in an output register until m_axis_tready takes it; a
// stalled result keeps the sequencer busy. Rejected requests and request
// type 3 present their result in the cycle after acceptance. The queue limit
// register may be written at any time and in effect saturates at DEPTH.

module bounded_priority_task_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_tag[15:0], requested_priority[18:16], entry_stamp[50:19], zeros above
  input  wire logic [55:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // popped_tag[15:0], popped_priority[17:16], popped_stamp[49:18],
  // fill_level[54:50], zeros above
  output logic      [55:0] m_axis_tdata,
  // status[1:0]
  output logic      [1:0]  m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CmpW = (CW > bptq_pkg::LimitW) ? CW : bptq_pkg::LimitW;
  localparam int unsigned EntW = $bits(bptq_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_POP_RD,
    S_POP_TAKE,
    S_RESULT
  } state_e;

  state_e                              state_q;
  bptq_pkg::entry_t                    new_q;
  logic [AW-1:0]                       head_q;
  logic [CW-1:0]                       count_q;
  logic [CW-1:0]                       idx_q;
  logic [CW-1:0]                       pos_q;
  logic [bptq_pkg::LimitW-1:0]         limit_q;
  bptq_pkg::status_e                   res_status_q;
  logic [bptq_pkg::TagW-1:0]           res_tag_q;
  logic [bptq_pkg::OutPrioW-1:0]       res_prio_q;
  logic [bptq_pkg::StampW-1:0]         res_stamp_q;
  logic [bptq_pkg::FillW-1:0]          res_fill_q;

  bptq_pkg::entry_t                    in_entry;
  bptq_pkg::req_e                      in_req;
  logic [bptq_pkg::PrioW-1:0]          raw_prio;
  logic                                in_accept;
  logic                                full;
  logic                                goes_first;

  logic                                ram_we;
  logic [AW-1:0]                       ram_waddr;
  bptq_pkg::entry_t                    ram_wdata;
  logic                                ram_re;
  logic [AW-1:0]                       ram_raddr;
  logic [EntW-1:0]                     ram_rdata;
  bptq_pkg::entry_t                    held_entry;

  // circular slot of offset off from base; one subtraction wraps sums below twice DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_req   = bptq_pkg::req_e'(s_axis_tuser);
  assign raw_prio = s_axis_tdata[18:16];

  always_comb begin
    in_entry.tag   = s_axis_tdata[15:0];
    in_entry.stamp = s_axis_tdata[50:19];
    if (raw_prio >= bptq_pkg::PrioW'(1) &&
        raw_prio <= bptq_pkg::PrioW'(bptq_pkg::PrioLevels)) begin
      in_entry.prio = raw_prio;
    end else begin
      in_entry.prio = bptq_pkg::DefaultPrio;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign full = (CmpW'(count_q) >= CmpW'(limit_q)) || (count_q >= CW'(DEPTH));

  assign held_entry = bptq_pkg::entry_t'(ram_rdata);

  bptq_cmp u_cmp (
    .new_i    (new_q),
    .held_i   (held_entry),
    .before_o (goes_first)
  );

  // ram port control follows the sequencer state
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = slot_of(head_q, idx_q);
    ram_we    = 1'b0;
    ram_waddr = slot_of(head_q, idx_q);
    ram_wdata = held_entry;
    case (state_q)
      S_SRCH_RD: begin
        ram_re = 1'b1;
      end
      S_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = slot_of(head_q, idx_q - CW'(1));
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(head_q, pos_q);
        ram_wdata = new_q;
      end
      S_POP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_q;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  bptq_ram #(
    .WIDTH (EntW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (EntW'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      new_q        <= '0;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      limit_q      <= bptq_pkg::LimitW'(16);
      res_status_q <= bptq_pkg::STAT_DONE;
      res_tag_q    <= '0;
      res_prio_q   <= '0;
      res_stamp_q  <= '0;
      res_fill_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            new_q        <= in_entry;
            res_status_q <= bptq_pkg::STAT_DONE;
            res_tag_q    <= '0;
            res_prio_q   <= '0;
            res_stamp_q  <= '0;
            res_fill_q   <= bptq_pkg::FillW'(count_q);
            case (in_req)
              bptq_pkg::REQ_TAIL, bptq_pkg::REQ_ORDER: begin
                if (full) begin
                  res_status_q <= bptq_pkg::STAT_FULL;
                  state_q      <= S_RESULT;
                end else if (in_req == bptq_pkg::REQ_ORDER) begin
                  idx_q   <= '0;
                  state_q <= S_SRCH_RD;
                end else begin
                  idx_q   <= count_q;
                  pos_q   <= count_q;
                  state_q <= S_SHIFT_RD;
                end
              end
              bptq_pkg::REQ_POP: begin
                if (count_q == '0) begin
                  res_status_q <= bptq_pkg::STAT_EMPTY;
                  state_q      <= S_RESULT;
                end else begin
                  state_q <= S_POP_RD;
                end
              end
              default: begin
                state_q <= S_RESULT;
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          if (idx_q == count_q) begin
            // nothing held sorts after the new entry: append
            pos_q   <= count_q;
            state_q <= S_SHIFT_RD;
          end else begin
            state_q <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (goes_first) begin
            pos_q   <= idx_q;
            idx_q   <= count_q;
            state_q <= S_SHIFT_RD;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_SRCH_RD;
          end
        end
        S_SHIFT_RD: begin
          if (idx_q == pos_q) begin
            state_q <= S_INSERT;
          end else begin
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx_q   <= idx_q - CW'(1);
          state_q <= S_SHIFT_RD;
        end
        S_INSERT: begin
          count_q    <= count_q + CW'(1);
          res_fill_q <= bptq_pkg::FillW'(count_q + CW'(1));
          state_q    <= S_RESULT;
        end
        S_POP_RD: begin
          state_q <= S_POP_TAKE;
        end
        S_POP_TAKE: begin
          res_tag_q   <= held_entry.tag;
          res_prio_q  <= held_entry.prio[bptq_pkg::OutPrioW-1:0];
          res_stamp_q <= held_entry.stamp;
          res_fill_q  <= bptq_pkg::FillW'(count_q - CW'(1));
          head_q      <= slot_of(head_q, CW'(1));
          count_q     <= count_q - CW'(1);
          state_q     <= S_RESULT;
        end
        S_RESULT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == S_RESULT);
  assign m_axis_tuser  = res_status_q;
  assign m_axis_tdata  = {1'b0, res_fill_q, res_stamp_q, res_prio_q, res_tag_q};

endmodule

`default_nettype wire

// ===== verif/bounded_priority_task_queue_unit_test.sv =====
// testbench for bounded_priority_task_queue_unit: directed and random request streams
// checked against an in-bench queue predictor; depends on bptq_pkg and the unit itself
`timescale 1ns / 1ps

module bounded_priority_task_queue_unit_test;

  localparam int unsigned QueueDepth = 16;

  typedef struct {
    logic [bptq_pkg::TagW-1:0]     tag;
    logic [bptq_pkg::OutPrioW-1:0] prio;
    logic [bptq_pkg::StampW-1:0]   stamp;
  } slot_t;

  typedef struct packed {
    bptq_pkg::status_e             status;
    logic [bptq_pkg::TagW-1:0]     tag;
    logic [bptq_pkg::OutPrioW-1:0] prio;
    logic [bptq_pkg::StampW-1:0]   stamp;
    logic [bptq_pkg::FillW-1:0]    fill;
  } outcome_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bptq_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [bptq_pkg::KindW-1:0]    s_axis_tuser  = bptq_pkg::REQ_NONE;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bptq_pkg::OutDataW-1:0] m_axis_tdata;
  logic [bptq_pkg::KindW-1:0]    m_axis_tuser;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [bptq_pkg::LimitW-1:0]   cfg_data_i    = '0;

  // predictor state
  slot_t                       held_entries[$];
  logic [bptq_pkg::LimitW-1:0] limit_reg = bptq_pkg::LimitW'(16);
  outcome_t                    pending_results[$];

  int unsigned burst_left   = 0;
  int unsigned sent_count   = 0;
  int unsigned checked      = 0;
  int unsigned full_seen    = 0;
  int unsigned empty_seen   = 0;
  int unsigned popped_seen  = 0;
  int unsigned peak_fill    = 0;
  int unsigned errors       = 0;

  bounded_priority_task_queue_unit #(
    .DEPTH(QueueDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // queue behaviour for one request; updates the held entries
  function automatic outcome_t serve_request(bptq_pkg::req_e kind,
                                             logic [bptq_pkg::TagW-1:0] tag,
                                             logic [bptq_pkg::PrioW-1:0] raw_prio,
                                             logic [bptq_pkg::StampW-1:0] stamp);
    outcome_t    res;
    slot_t       ent;
    int unsigned cap;
    int unsigned pos;
    bit          placed;
    res        = '0;
    res.status = bptq_pkg::STAT_DONE;
    ent.tag    = tag;
    ent.prio   = (raw_prio >= 1 && raw_prio <= bptq_pkg::PrioLevels)
                 ? raw_prio[bptq_pkg::OutPrioW-1:0]
                 : bptq_pkg::DefaultPrio[bptq_pkg::OutPrioW-1:0];
    ent.stamp  = stamp;
    cap        = (limit_reg > QueueDepth) ? QueueDepth : limit_reg;
    case (kind)
      bptq_pkg::REQ_TAIL, bptq_pkg::REQ_ORDER: begin
        if (held_entries.size() >= cap) begin
          res.status = bptq_pkg::STAT_FULL;
        end else begin
          pos    = held_entries.size();
          placed = 1'b0;
          if (kind == bptq_pkg::REQ_ORDER) begin
            for (int i = 0; i < held_entries.size(); i++) begin
              if (!placed && (ent.prio < held_entries[i].prio ||
                  (ent.prio == held_entries[i].prio && stamp < held_entries[i].stamp))) begin
                pos    = i;
                placed = 1'b1;
              end
            end
          end
          held_entries.insert(pos, ent);
        end
      end
      bptq_pkg::REQ_POP: begin
        if (held_entries.size() == 0) begin
          res.status = bptq_pkg::STAT_EMPTY;
        end else begin
          ent       = held_entries.pop_front();
          res.tag   = ent.tag;
          res.prio  = ent.prio;
          res.stamp = ent.stamp;
        end
      end
      default: ;
    endcase
    res.fill = bptq_pkg::FillW'(held_entries.size());
    return res;
  endfunction

  // one transaction on the request side, in bursts with random gaps
  task automatic send_request(input bptq_pkg::req_e kind,
                              input logic [bptq_pkg::TagW-1:0] tag,
                              input logic [bptq_pkg::PrioW-1:0] prio,
                              input logic [bptq_pkg::StampW-1:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(bptq_pkg::InDataW - bptq_pkg::StampW - bptq_pkg::PrioW
                        - bptq_pkg::TagW){1'b0}}, stamp, prio, tag};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(serve_request(kind, tag, prio, stamp));
    sent_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [bptq_pkg::LimitW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = value;
  endtask

  task automatic send_random(input int unsigned push_pct);
    int unsigned                 pick;
    bptq_pkg::req_e              kind;
    logic [bptq_pkg::PrioW-1:0]  prio;
    logic [bptq_pkg::StampW-1:0] stamp;
    pick = $urandom_range(0, 99);
    if (pick < 3) kind = bptq_pkg::REQ_NONE;
    else if (pick < push_pct) begin
      kind = ($urandom_range(0, 99) < 65) ? bptq_pkg::REQ_ORDER : bptq_pkg::REQ_TAIL;
    end
    else kind = bptq_pkg::REQ_POP;
    prio = ($urandom_range(0, 9) < 4) ? bptq_pkg::PrioW'($urandom_range(0, 7))
                                      : bptq_pkg::PrioW'($urandom_range(1,
                                                         bptq_pkg::PrioLevels));
    // small stamps make equal-priority ties and equal stamps frequent
    case ($urandom_range(0, 9))
      0:             stamp = '0;
      1:             stamp = '1;
      2, 3, 4, 5:    stamp = bptq_pkg::StampW'($urandom_range(0, 7));
      default:       stamp = bptq_pkg::StampW'($urandom);
    endcase
    send_request(kind, bptq_pkg::TagW'($urandom), prio, stamp);
  endtask

  // receiver stalls on a rotating 16-bit pattern, redrawn each time the step wraps
  logic [15:0] ready_pattern = '1;
  int unsigned ready_step    = 0;
  always @(posedge clk_i) begin
    if (ready_step == 15) begin
      case ($urandom_range(0, 4))
        0, 1:    ready_pattern = '1;
        2:       ready_pattern = 16'($urandom);
        3:       ready_pattern = 16'($urandom) | 16'($urandom);
        default: ready_pattern = 16'h8000;
      endcase
    end
    ready_step = (ready_step + 1) % 16;
    m_axis_tready <= ready_pattern[ready_step];
  end

  always @(posedge clk_i) begin : check_results
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = bptq_pkg::status_e'(m_axis_tuser);
      got.tag    = m_axis_tdata[15:0];
      got.prio   = m_axis_tdata[17:16];
      got.stamp  = m_axis_tdata[49:18];
      got.fill   = m_axis_tdata[54:50];
      if (pending_results.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected result at %0t: status %0d tag %h fill %0d",
                   $realtime, got.status, got.tag, got.fill);
        end
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.status != want.status || got.tag != want.tag || got.prio != want.prio ||
            got.stamp != want.stamp || got.fill != want.fill) begin
          if (errors < 10) begin
            $display("mismatch at %0t: expected status %0d tag %h prio %0d stamp %h fill %0d",
                     $realtime, want.status, want.tag, want.prio, want.stamp, want.fill);
            $display("                  actual status %0d tag %h prio %0d stamp %h fill %0d",
                     got.status, got.tag, got.prio, got.stamp, got.fill);
          end
          errors++;
        end
        if (want.status == bptq_pkg::STAT_FULL) full_seen++;
        if (want.status == bptq_pkg::STAT_EMPTY) empty_seen++;
        // a served pop always returns a non-zero priority
        if (want.status == bptq_pkg::STAT_DONE && want.prio != 0) popped_seen++;
        if (want.fill > peak_fill) peak_fill = want.fill;
      end
    end
  end

  // extremes of each field, both push kinds, ties and the idle request type
  task automatic test_basic_ordering();
    send_request(bptq_pkg::REQ_POP,   16'h0000, 3'd0, 32'h0000_0000);
    send_request(bptq_pkg::REQ_NONE,  16'hffff, 3'd7, 32'hffff_ffff);
    send_request(bptq_pkg::REQ_TAIL,  16'h0000, 3'd0, 32'h0000_0000);
    send_request(bptq_pkg::REQ_TAIL,  16'hffff, 3'd7, 32'hffff_ffff);
    send_request(bptq_pkg::REQ_TAIL,  16'h1111, 3'd3, 32'h0000_0001);
    send_request(bptq_pkg::REQ_ORDER, 16'h2222, 3'd1, 32'h0000_0005);
    send_request(bptq_pkg::REQ_ORDER, 16'h3333, 3'd3, 32'h0000_0000);
    send_request(bptq_pkg::REQ_ORDER, 16'h4444, 3'd2, 32'h0000_0000);
    send_request(bptq_pkg::REQ_ORDER, 16'h5555, 3'd2, 32'hffff_ffff);
    send_request(bptq_pkg::REQ_ORDER, 16'h6666, 3'd4, 32'h0000_0007);
    send_request(bptq_pkg::REQ_ORDER, 16'h7777, 3'd1, 32'h0000_0005);
    send_request(bptq_pkg::REQ_ORDER, 16'h8888, 3'd6, 32'h8000_0000);
    send_request(bptq_pkg::REQ_NONE,  16'h0000, 3'd0, 32'h0000_0000);
    repeat (11) send_request(bptq_pkg::REQ_POP, 16'hffff, 3'd7, 32'hffff_ffff);
    send_request(bptq_pkg::REQ_POP,   16'h0000, 3'd0, 32'h0000_0000);
  endtask

  task automatic test_limit_edges();
    set_limit(5'd0);
    send_request(bptq_pkg::REQ_TAIL,  16'habcd, 3'd1, 32'h0000_0010);
    send_request(bptq_pkg::REQ_ORDER, 16'hbcde, 3'd2, 32'h0000_0020);
    send_request(bptq_pkg::REQ_POP,   16'h0000, 3'd0, 32'h0000_0000);
    set_limit(5'd1);
    send_request(bptq_pkg::REQ_ORDER, 16'h1234, 3'd3, 32'h0000_0030);
    send_request(bptq_pkg::REQ_TAIL,  16'h2345, 3'd1, 32'h0000_0040);
    send_request(bptq_pkg::REQ_POP,   16'h0000, 3'd0, 32'h0000_0000);
    send_request(bptq_pkg::REQ_POP,   16'h0000, 3'd0, 32'h0000_0000);
    // limit above the depth saturates
    set_limit(5'd31);
    repeat (QueueDepth + 1) begin
      send_request(bptq_pkg::REQ_ORDER, bptq_pkg::TagW'($urandom),
                   bptq_pkg::PrioW'($urandom_range(0, 7)),
                   bptq_pkg::StampW'($urandom_range(0, 5)));
    end
    // limit dropped under the current fill keeps entries but blocks pushes
    set_limit(5'd4);
    send_request(bptq_pkg::REQ_TAIL, 16'h0f0f, 3'd1, 32'h0000_0001);
    repeat (QueueDepth - 3) begin
      send_request(bptq_pkg::REQ_POP, 16'h0000, 3'd0, 32'h0000_0000);
    end
    send_request(bptq_pkg::REQ_ORDER, 16'hf0f0, 3'd1, 32'h0000_0002);
    send_request(bptq_pkg::REQ_ORDER, 16'h0ff0, 3'd1, 32'h0000_0003);
  endtask

  task automatic test_random_traffic();
    logic [bptq_pkg::LimitW-1:0] limits[10];
    limits = '{5'd16, 5'd5, 5'd31, 5'd2, 5'd17, 5'd9, 5'd1, 5'd16, 5'd24, 5'd0};
    limits[5] = bptq_pkg::LimitW'($urandom_range(1, 31));
    foreach (limits[p]) begin
      set_limit(limits[p]);
      for (int n = 0; n < 67; n++) begin
        send_random((n < 40) ? 80 : 30);
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end
    set_limit(5'd16);
    repeat (20) send_random(50);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ordering();
    test_limit_edges();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk_i);
    errors += pending_results.size();
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             sent_count, checked, errors);
    $display("full rejects %0d, empty rejects %0d, entries popped %0d, peak fill %0d",
             full_seen, empty_seen, popped_seen, peak_fill);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bptq_pkg.sv
sv/bptq_ram.sv
sv/bptq_cmp.sv
sv/bounded_priority_task_queue_unit.sv
verif/bounded_priority_task_queue_unit_test.sv
